// ===== design/kbt_pkg.sv =====
// Shared types, codes and constants of the k-bucket contact table.
package kbt_pkg;

    localparam int unsigned BUCKET_DEPTH_DEFAULT = 16;
    localparam int unsigned ID_W = 160;
    localparam int unsigned INFO_W = 64;
    localparam int unsigned CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_POP    = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] id_high;
        logic [63:0] id_mid;
        logic [63:0] id_low;
        logic [63:0] contact_info;
        logic [4:0]  wanted_count;
    } kbt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] out_id_high;
        logic [63:0] out_id_mid;
        logic [63:0] out_id_low;
        logic [63:0] out_info;
        logic        last;
    } kbt_out_t;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [INFO_W-1:0] info;
    } kbt_entry_t;

    typedef struct packed {
        logic [ID_W-1:0] distance;
        logic            nearer;
    } kbt_cmp_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CHK,
        S_EMIT,
        S_SH_RD,
        S_SH_WR,
        S_SH_END,
        S_INS_END
    } kbt_state_t;

endpackage

// ===== design/kbt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module kbt_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/kbt_dist.sv =====
// Shared XOR distance unit: distance of an entry to the target against the best so far.
module kbt_dist (
    input  logic [kbt_pkg::ID_W-1:0] entry_id,
    input  logic [kbt_pkg::ID_W-1:0] target,
    input  logic [kbt_pkg::ID_W-1:0] best_dist,
    output kbt_pkg::kbt_cmp_t        cmp
);

    always_comb
    begin
        cmp.distance = entry_id ^ target;
        cmp.nearer   = (entry_id ^ target) < best_dist;
    end

endmodule

// ===== design/kademlia_kbucket_table_top.sv =====
// Top level of the k-bucket contact table: sequencer, entry RAM and distance unit.
//
// Items enter on cmd when start is high and busy is low; kind selects insert,
// pop of the oldest contact or closest query. Each result appears on result
// for one cycle with result_valid high; last marks the final result of an
// item. The receiver cannot stall, so results are never held.
// cfg_ready is always high; the user must write the capacity register over
// cfg_valid/cfg_ready/cfg_data only while idle, which the block does not enforce.
// Every entry is read from the single RAM read port and then checked. Insert
// of a new id scans the table, then appends or rejects. Refresh of an id
// scans up to it, moves every later entry up one place and writes the id at
// the tail. Pop reads the oldest entry and moves every later entry up.
// A query returning all reads the entries in order. A nearest query for w
// contacts sweeps the table once per result with the one shared XOR
// distance comparator.
// An empty-status result and an unused kind do not make the block busy.
// Reset empties the table and sets the capacity to 16; the RAM is not
// cleared, as entries at or above the occupancy are never read.
module kademlia_kbucket_table_top #(
    parameter int unsigned BUCKET_DEPTH = kbt_pkg::BUCKET_DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  kbt_pkg::kbt_in_t            cmd,
    output logic                        result_valid,
    output kbt_pkg::kbt_out_t           result,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kbt_pkg::CAP_W-1:0]   cfg_data
);

    localparam int unsigned IDXW = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
    localparam int unsigned CNTW = $clog2(BUCKET_DEPTH + 1);
    localparam int unsigned CMPW = (CNTW > kbt_pkg::CAP_W) ? CNTW : kbt_pkg::CAP_W;
    localparam logic [CNTW-1:0] ONE_C   = CNTW'(1);
    localparam logic [CNTW-1:0] DEPTH_C = CNTW'(BUCKET_DEPTH);

    kbt_pkg::kbt_state_t state_reg, state_next;
    kbt_pkg::kbt_in_t    req_reg, req_next;
    kbt_pkg::kbt_out_t   res_reg, res_next;
    kbt_pkg::kbt_entry_t best_reg, best_next;
    logic                res_valid_reg, res_valid_next;
    logic [CNTW-1:0]     idx_reg, idx_next;
    logic [CNTW-1:0]     k_reg, k_next;
    logic [CNTW-1:0]     occ_reg, occ_next;
    logic [kbt_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic [BUCKET_DEPTH-1:0]   used_reg, used_next;
    logic                have_best_reg, have_best_next;
    logic                all_reg, all_next;
    logic [kbt_pkg::ID_W-1:0] best_dist_reg, best_dist_next;
    logic [IDXW-1:0]     best_idx_reg, best_idx_next;

    logic                ram_we;
    logic [IDXW-1:0]     ram_waddr;
    logic [IDXW-1:0]     ram_raddr;
    kbt_pkg::kbt_entry_t ram_wdata;
    kbt_pkg::kbt_entry_t ram_rdata;
    kbt_pkg::kbt_cmp_t   cmp;

    logic [CNTW-1:0]     idx_inc;
    logic [CNTW-1:0]     occ_dec;
    logic [kbt_pkg::ID_W-1:0] req_id;
    logic                room;
    logic                q_last;

    kbt_ram #(
        .WIDTH ($bits(kbt_pkg::kbt_entry_t)),
        .DEPTH (BUCKET_DEPTH),
        .AW    (IDXW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    kbt_dist u_dist (
        .entry_id  (ram_rdata.id),
        .target    (req_id),
        .best_dist (best_dist_reg),
        .cmp       (cmp)
    );

    assign req_id  = {req_reg.id_high, req_reg.id_mid, req_reg.id_low};
    assign idx_inc = idx_reg + ONE_C;
    assign occ_dec = occ_reg - ONE_C;
    assign room    = (CMPW'(occ_reg) < CMPW'(cap_reg)) && (occ_reg < DEPTH_C);
    assign q_last  = (CMPW'(k_reg) + CMPW'(1)) == CMPW'(req_reg.wanted_count);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= kbt_pkg::S_IDLE;
            res_valid_reg <= 1'b0;
            occ_reg       <= '0;
            cap_reg       <= kbt_pkg::CAP_RESET;
            idx_reg       <= '0;
            k_reg         <= '0;
            used_reg      <= '0;
            have_best_reg <= 1'b0;
            all_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            occ_reg       <= occ_next;
            cap_reg       <= cap_next;
            idx_reg       <= idx_next;
            k_reg         <= k_next;
            used_reg      <= used_next;
            have_best_reg <= have_best_next;
            all_reg       <= all_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        res_reg       <= res_next;
        best_reg      <= best_next;
        best_dist_reg <= best_dist_next;
        best_idx_reg  <= best_idx_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        res_next       = res_reg;
        res_valid_next = 1'b0;
        occ_next       = occ_reg;
        cap_next       = cap_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        used_next      = used_reg;
        have_best_next = have_best_reg;
        all_next       = all_reg;
        best_next      = best_reg;
        best_dist_next = best_dist_reg;
        best_idx_next  = best_idx_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[IDXW-1:0];
        ram_raddr      = idx_reg[IDXW-1:0];
        ram_wdata      = ram_rdata;

        if (cfg_valid)
        begin
            cap_next = cfg_data;
        end

        case (state_reg)
            kbt_pkg::S_IDLE:
            begin
                if (start)
                begin
                    req_next = cmd;
                    idx_next = '0;
                    k_next   = '0;
                    case (cmd.kind)
                        kbt_pkg::KIND_INSERT:
                        begin
                            state_next = (occ_reg == '0) ? kbt_pkg::S_INS_END
                                                         : kbt_pkg::S_RD;
                        end
                        kbt_pkg::KIND_POP,
                        kbt_pkg::KIND_QUERY:
                        begin
                            if (occ_reg == '0 ||
                                (cmd.kind == kbt_pkg::KIND_QUERY && cmd.wanted_count == '0))
                            begin
                                res_next       = '0;
                                res_next.status = kbt_pkg::ST_EMPTY;
                                res_next.last   = 1'b1;
                                res_valid_next  = 1'b1;
                            end
                            else
                            begin
                                all_next       = CMPW'(cmd.wanted_count) >= CMPW'(occ_reg);
                                used_next      = '0;
                                have_best_next = 1'b0;
                                state_next     = kbt_pkg::S_RD;
                            end
                        end
                        default:
                        begin
                            state_next = kbt_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            kbt_pkg::S_RD:
            begin
                state_next = kbt_pkg::S_CHK;
            end

            kbt_pkg::S_CHK:
            begin
                case (req_reg.kind)
                    kbt_pkg::KIND_INSERT:
                    begin
                        if (ram_rdata.id == req_id)
                        begin
                            state_next = (idx_inc < occ_reg) ? kbt_pkg::S_SH_RD
                                                             : kbt_pkg::S_SH_END;
                        end
                        else
                        begin
                            idx_next   = idx_inc;
                            state_next = (idx_inc == occ_reg) ? kbt_pkg::S_INS_END
                                                              : kbt_pkg::S_RD;
                        end
                    end
                    kbt_pkg::KIND_POP:
                    begin
                        res_next.status      = kbt_pkg::ST_OK;
                        res_next.out_id_high = ram_rdata.id[159:128];
                        res_next.out_id_mid  = ram_rdata.id[127:64];
                        res_next.out_id_low  = ram_rdata.id[63:0];
                        res_next.out_info    = ram_rdata.info;
                        res_next.last        = 1'b1;
                        res_valid_next       = 1'b1;
                        state_next = (idx_inc < occ_reg) ? kbt_pkg::S_SH_RD
                                                         : kbt_pkg::S_SH_END;
                    end
                    default:
                    begin
                        if (all_reg)
                        begin
                            res_next.status      = kbt_pkg::ST_OK;
                            res_next.out_id_high = ram_rdata.id[159:128];
                            res_next.out_id_mid  = ram_rdata.id[127:64];
                            res_next.out_id_low  = ram_rdata.id[63:0];
                            res_next.out_info    = ram_rdata.info;
                            res_next.last        = (idx_inc == occ_reg);
                            res_valid_next       = 1'b1;
                            idx_next             = idx_inc;
                            state_next = (idx_inc == occ_reg) ? kbt_pkg::S_IDLE
                                                              : kbt_pkg::S_RD;
                        end
                        else
                        begin
                            if (!used_reg[idx_reg[IDXW-1:0]] &&
                                (!have_best_reg || cmp.nearer))
                            begin
                                best_next      = ram_rdata;
                                best_dist_next = cmp.distance;
                                best_idx_next  = idx_reg[IDXW-1:0];
                                have_best_next = 1'b1;
                            end
                            idx_next   = idx_inc;
                            state_next = (idx_inc == occ_reg) ? kbt_pkg::S_EMIT
                                                              : kbt_pkg::S_RD;
                        end
                    end
                endcase
            end

            kbt_pkg::S_EMIT:
            begin
                res_next.status           = kbt_pkg::ST_OK;
                res_next.out_id_high      = best_reg.id[159:128];
                res_next.out_id_mid       = best_reg.id[127:64];
                res_next.out_id_low       = best_reg.id[63:0];
                res_next.out_info         = best_reg.info;
                res_next.last             = q_last;
                res_valid_next            = 1'b1;
                used_next[best_idx_reg]   = 1'b1;
                k_next                    = k_reg + ONE_C;
                have_best_next            = 1'b0;
                idx_next                  = '0;
                state_next = q_last ? kbt_pkg::S_IDLE : kbt_pkg::S_RD;
            end

            kbt_pkg::S_SH_RD:
            begin
                ram_raddr  = idx_inc[IDXW-1:0];
                state_next = kbt_pkg::S_SH_WR;
            end

            kbt_pkg::S_SH_WR:
            begin
                ram_we     = 1'b1;
                ram_waddr  = idx_reg[IDXW-1:0];
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = ((idx_inc + ONE_C) < occ_reg) ? kbt_pkg::S_SH_RD
                                                           : kbt_pkg::S_SH_END;
            end

            kbt_pkg::S_SH_END:
            begin
                if (req_reg.kind == kbt_pkg::KIND_INSERT)
                begin
                    ram_we               = 1'b1;
                    ram_waddr            = occ_dec[IDXW-1:0];
                    ram_wdata.id         = req_id;
                    ram_wdata.info       = req_reg.contact_info;
                    res_next.status      = kbt_pkg::ST_OK;
                    res_next.out_id_high = req_reg.id_high;
                    res_next.out_id_mid  = req_reg.id_mid;
                    res_next.out_id_low  = req_reg.id_low;
                    res_next.out_info    = req_reg.contact_info;
                    res_next.last        = 1'b1;
                    res_valid_next       = 1'b1;
                end
                else
                begin
                    occ_next = occ_dec;
                end
                state_next = kbt_pkg::S_IDLE;
            end

            kbt_pkg::S_INS_END:
            begin
                res_next.status      = room ? kbt_pkg::ST_OK : kbt_pkg::ST_FULL;
                res_next.out_id_high = req_reg.id_high;
                res_next.out_id_mid  = req_reg.id_mid;
                res_next.out_id_low  = req_reg.id_low;
                res_next.out_info    = req_reg.contact_info;
                res_next.last        = 1'b1;
                res_valid_next       = 1'b1;
                if (room)
                begin
                    ram_we         = 1'b1;
                    ram_waddr      = occ_reg[IDXW-1:0];
                    ram_wdata.id   = req_id;
                    ram_wdata.info = req_reg.contact_info;
                    occ_next       = occ_reg + ONE_C;
                end
                state_next = kbt_pkg::S_IDLE;
            end

            default:
            begin
                state_next = kbt_pkg::S_IDLE;
            end
        endcase
    end

    assign busy         = (state_reg != kbt_pkg::S_IDLE);
    assign cfg_ready    = 1'b1;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // occupancy stays within the table
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_C)
        else $error("occupancy beyond table depth");

    // an insert always runs the sequencer
    a_insert_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd.kind == kbt_pkg::KIND_INSERT) |=> busy)
        else $error("insert accepted without going busy");

    // a result without a fresh idle item comes from the sequencer
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !$past(start && !busy)) |-> $past(busy))
        else $error("result from an idle sequencer");

    // nearest search emits only once a candidate was found
    a_emit_best: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == kbt_pkg::S_EMIT) |-> have_best_reg)
        else $error("nearest result without candidate");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench of the k-bucket contact table: predictor, stimulus and checks.
module tb;

    localparam int DEPTH = 16;
    localparam int MAX_CYCLES = 2000000;

    class bucket_scoreboard;
        logic [159:0] ids [$];
        logic [63:0]  infos [$];
        int unsigned  cap_limit;
        kbt_pkg::kbt_out_t pending [$];
        int unsigned  errors;

        function new();
            cap_limit = 16;
            errors = 0;
        endfunction

        function void push_result(logic [1:0] st, logic [159:0] id, logic [63:0] inf,
                                  logic lst);
            kbt_pkg::kbt_out_t r;
            r.status = st;
            r.out_id_high = id[159:128];
            r.out_id_mid = id[127:64];
            r.out_id_low = id[63:0];
            r.out_info = inf;
            r.last = lst;
            pending.insert(pending.size(), r);
        endfunction

        function void note_item(kbt_pkg::kbt_in_t c);
            logic [159:0] id;
            logic [159:0] best_d;
            logic [159:0] d;
            int unsigned lim;
            int n;
            int best;
            int want;
            bit taken [DEPTH];
            bit found;
            id = {c.id_high, c.id_mid, c.id_low};
            n = ids.size();
            want = c.wanted_count;
            found = 0;
            if (c.kind == kbt_pkg::KIND_INSERT)
            begin
                lim = (cap_limit < DEPTH) ? cap_limit : DEPTH;
                for (int i = 0; i < n && !found; i++)
                    if (ids[i] == id)
                    begin
                        ids.delete(i);
                        infos.delete(i);
                        found = 1;
                    end
                if (found || n < lim)
                begin
                    ids.insert(ids.size(), id);
                    infos.insert(infos.size(), c.contact_info);
                    push_result(kbt_pkg::ST_OK, id, c.contact_info, 1'b1);
                end
                else
                    push_result(kbt_pkg::ST_FULL, id, c.contact_info, 1'b1);
            end
            else if (c.kind == kbt_pkg::KIND_POP)
            begin
                if (n == 0)
                    push_result(kbt_pkg::ST_EMPTY, '0, '0, 1'b1);
                else
                begin
                    push_result(kbt_pkg::ST_OK, ids[0], infos[0], 1'b1);
                    void'(ids.pop_front());
                    void'(infos.pop_front());
                end
            end
            else if (c.kind == kbt_pkg::KIND_QUERY)
            begin
                if (n == 0 || want == 0)
                    push_result(kbt_pkg::ST_EMPTY, '0, '0, 1'b1);
                else if (want >= n)
                begin
                    for (int i = 0; i < n; i++)
                        push_result(kbt_pkg::ST_OK, ids[i], infos[i], i == n - 1);
                end
                else
                begin
                    foreach (taken[i]) taken[i] = 0;
                    for (int k = 0; k < want; k++)
                    begin
                        best = -1;
                        best_d = '0;
                        for (int i = 0; i < n; i++)
                        begin
                            d = ids[i] ^ id;
                            if (!taken[i] && (best < 0 || d < best_d))
                            begin
                                best = i;
                                best_d = d;
                            end
                        end
                        taken[best] = 1;
                        push_result(kbt_pkg::ST_OK, ids[best], infos[best], k == want - 1);
                    end
                end
            end
        endfunction

        function void check_result(kbt_pkg::kbt_out_t got);
            kbt_pkg::kbt_out_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.out_id_high !== exp.out_id_high
                || got.out_id_mid !== exp.out_id_mid || got.out_id_low !== exp.out_id_low
                || got.out_info !== exp.out_info || got.last !== exp.last)
            begin
                $display("%0t: mismatch expected %h actual %h", $realtime, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    kbt_pkg::kbt_in_t cmd;
    logic result_valid;
    kbt_pkg::kbt_out_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [kbt_pkg::CAP_W-1:0] cfg_data;

    bucket_scoreboard sb;
    logic [159:0] known_ids [$];
    int cycle_count;
    bit quiet;

    kademlia_kbucket_table_top u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .result_valid(result_valid), .result(result),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && result_valid)
            sb.check_result(result);
        if (cycle_count > MAX_CYCLES)
        begin
            $display("kademlia_kbucket_table_top regression: fail");
            $finish;
        end
    end

    // start stays high into the next item when there is no gap
    task automatic send_item(kbt_pkg::kbt_in_t c);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= c;
        start <= 1'b1;
        @(posedge clk);
        while (busy) @(posedge clk);
        sb.note_item(c);
        @(negedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_limit(logic [kbt_pkg::CAP_W-1:0] v);
        drain();
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        sb.cap_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic kbt_pkg::kbt_in_t make_item(logic [1:0] k, logic [159:0] id,
                                                   logic [63:0] inf, logic [4:0] w);
        kbt_pkg::kbt_in_t c;
        c.kind = k;
        {c.id_high, c.id_mid, c.id_low} = id;
        c.contact_info = inf;
        c.wanted_count = w;
        return c;
    endfunction

    function automatic logic [159:0] rand_id();
        logic [159:0] v;
        for (int i = 0; i < 5; i++) v[i*32 +: 32] = $urandom;
        return v;
    endfunction

    task automatic random_item();
        logic [159:0] id;
        logic [63:0] inf;
        int r;
        r = $urandom_range(0, 99);
        inf = {$urandom, $urandom};
        if (known_ids.size() != 0 && $urandom_range(0, 2) == 0)
            id = known_ids[$urandom_range(0, known_ids.size() - 1)];
        else
        begin
            id = rand_id();
            if ($urandom_range(0, 1)) id[159:150] = '0;
            known_ids.insert(known_ids.size(), id);
            if (known_ids.size() > 40) void'(known_ids.pop_front());
        end
        if (r < 50)
            send_item(make_item(kbt_pkg::KIND_INSERT, id, inf, 5'($urandom)));
        else if (r < 68)
            send_item(make_item(kbt_pkg::KIND_POP, id, inf, 5'($urandom)));
        else if (r < 97)
            send_item(make_item(kbt_pkg::KIND_QUERY, id, inf, 5'($urandom_range(0, 17))));
        else
            send_item(make_item(kbt_pkg::KIND_UNUSED, id, inf, 5'($urandom)));
    endtask

    initial
    begin
        logic [4:0] limits [5];
        sb = new();
        cycle_count = 0;
        quiet = 0;
        rst_n = 0;
        start = 0;
        cmd = '0;
        cfg_valid = 0;
        cfg_data = '0;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed
        send_item(make_item(kbt_pkg::KIND_POP, '0, '0, 5'd0));
        send_item(make_item(kbt_pkg::KIND_QUERY, '1, '1, 5'd16));
        send_item(make_item(kbt_pkg::KIND_INSERT, '0, '0, 5'd0));
        send_item(make_item(kbt_pkg::KIND_INSERT, '1, '1, 5'd31));
        send_item(make_item(kbt_pkg::KIND_INSERT, 160'h5, 64'h1234, 5'd0));
        send_item(make_item(kbt_pkg::KIND_INSERT, '0, 64'h99, 5'd0));
        send_item(make_item(kbt_pkg::KIND_QUERY, 160'h4, '0, 5'd0));
        send_item(make_item(kbt_pkg::KIND_QUERY, 160'h4, '0, 5'd31));
        send_item(make_item(kbt_pkg::KIND_QUERY, 160'h4, '0, 5'd2));
        send_item(make_item(kbt_pkg::KIND_QUERY, '1, '0, 5'd1));
        send_item(make_item(kbt_pkg::KIND_UNUSED, '1, '1, 5'd1));
        for (int i = 0; i < 16; i++)
            send_item(make_item(kbt_pkg::KIND_INSERT, rand_id(), {$urandom, $urandom}, 5'd0));
        send_item(make_item(kbt_pkg::KIND_QUERY, '0, '0, 5'd15));
        send_item(make_item(kbt_pkg::KIND_POP, '0, '0, 5'd0));
        write_limit(5'd1);
        send_item(make_item(kbt_pkg::KIND_INSERT, '1, 64'h7, 5'd0));
        send_item(make_item(kbt_pkg::KIND_INSERT, 160'h77, 64'h7, 5'd0));
        write_limit(5'd0);
        for (int i = 0; i < 20; i++)
            send_item(make_item(kbt_pkg::KIND_POP, '0, '0, 5'd0));
        send_item(make_item(kbt_pkg::KIND_INSERT, 160'h77, 64'h7, 5'd0));
        write_limit(5'd31);

        limits[0] = 5'd16; limits[1] = 5'd4; limits[2] = 5'd1;
        limits[3] = 5'd31; limits[4] = 5'd9;
        for (int p = 0; p < 5; p++)
        begin
            write_limit(limits[p]);
            if (p == 4) quiet = 1;
            for (int i = 0; i < 44; i++) random_item();
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("kademlia_kbucket_table_top regression: pass");
        else
            $display("kademlia_kbucket_table_top regression: fail");
        $finish;
    end
endmodule

// ===== sim.f =====
design/kbt_pkg.sv
design/kbt_ram.sv
design/kbt_dist.sv
design/kademlia_kbucket_table_top.sv
tb/tb.sv
